/* hdl/assert_macros.svh */
// Assertion macros shared by the rate meter RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MWRM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define MWRM_NEVER(name, cond, msg) \
  `MWRM_ASSERT(name, !(cond), msg)

`endif

/* hdl/mwrm_pkg.sv */
// Shared types and constants of the moving window rate meter.
// Used by every module of the block; depends on nothing.
package mwrm_pkg;

  // Ring and field sizes.
  localparam int unsigned MaxWindow  = 128;
  localparam int unsigned PosW       = $clog2(MaxWindow);
  localparam int unsigned CountW     = PosW + 1;
  localparam int unsigned IntervalW  = 24;
  localparam int unsigned SumW       = IntervalW + PosW;
  localparam int unsigned RateQ8W    = 28;
  localparam int unsigned RateIntW   = 20;
  localparam int unsigned WinW       = 8;
  localparam int unsigned StepW      = $clog2(SumW + 1);

  // Register reset value and rate saturation values.
  localparam logic [WinW-1:0]     WIN_RESET    = WinW'(70);
  localparam logic [WinW-1:0]     WIN_MAX      = WinW'(MaxWindow);
  localparam logic [RateQ8W-1:0]  RATE_Q8_MAX  = RateQ8W'(256000000);
  localparam logic [RateIntW-1:0] RATE_INT_MAX = RateIntW'(1000000);
  localparam logic [RateQ8W:0]    ROUND_HALF   = (RateQ8W+1)'(128);

  // Divider step counts: full width for the average, 28 bits for the rate.
  localparam logic [StepW-1:0] STEPS_AVG  = StepW'(SumW);
  localparam logic [StepW-1:0] STEPS_RATE = StepW'(RateQ8W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_AVG_START,
    ST_AVG_RUN,
    ST_CHECK,
    ST_RATE_RUN,
    ST_DONE
  } mwrm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic update;
    logic avg_start;
    logic avg_capture;
    logic rate_start;
    logic out_load;
    logic cfg_write;
  } mwrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic avg_zero;
  } mwrm_status_t;

endpackage

/* hdl/mwrm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on mwrm_pkg for widths.
module mwrm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mwrm_pkg::SumW-1:0]          dividend_i,
  input  logic [mwrm_pkg::IntervalW-1:0]     divisor_i,
  input  logic [mwrm_pkg::StepW-1:0]         steps_i,
  output logic                               busy_o,
  output logic [mwrm_pkg::SumW-1:0]          quotient_o
);

  logic [mwrm_pkg::StepW-1:0]     count_q, count_d;
  logic [mwrm_pkg::SumW-1:0]      quo_q, quo_d;
  logic [mwrm_pkg::IntervalW-1:0] rem_q, rem_d;
  logic [mwrm_pkg::IntervalW-1:0] div_q, div_d;
  logic [mwrm_pkg::IntervalW:0]   rem_shift;
  logic [mwrm_pkg::IntervalW:0]   rem_sub;
  logic                           ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem_q, quo_q[mwrm_pkg::SumW-1]};
    ge        = rem_shift >= {1'b0, div_q};
    rem_sub   = rem_shift - {1'b0, div_q};
    count_d   = count_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_d     = div_q;
    if (start_i) begin
      count_d = steps_i;
      quo_d   = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (count_q != '0) begin
      count_d = count_q - 1'b1;
      quo_d   = {quo_q[mwrm_pkg::SumW-2:0], ge};
      rem_d   = ge ? rem_sub[mwrm_pkg::IntervalW-1:0] : rem_shift[mwrm_pkg::IntervalW-1:0];
    end
  end

  // The step counter is control state; the operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = count_q != '0;
  assign quotient_o = quo_q;

endmodule

/* hdl/mwrm_datapath.sv */
// Datapath of the rate meter: interval ring, running sum, divider and output register.
// Depends on mwrm_pkg and mwrm_div.
module mwrm_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mwrm_pkg::mwrm_cmd_t                cmd_i,
  output mwrm_pkg::mwrm_status_t             status_o,
  input  logic [mwrm_pkg::WinW-1:0]          cfg_data_i,
  input  logic [mwrm_pkg::IntervalW-1:0]     elapsed_us_i,
  output logic [mwrm_pkg::RateQ8W-1:0]       rate_q8_o,
  output logic [mwrm_pkg::RateIntW-1:0]      rate_rounded_o,
  output logic                               zero_average_o
);

  // Control state of the window.
  logic [mwrm_pkg::WinW-1:0]      win_q;
  logic [mwrm_pkg::PosW-1:0]      wpos_q;
  logic [mwrm_pkg::CountW-1:0]    filled_q;
  logic [mwrm_pkg::SumW-1:0]      sum_q;

  // Per-transaction payload.
  logic [mwrm_pkg::IntervalW-1:0] ring_q [mwrm_pkg::MaxWindow];
  logic [mwrm_pkg::IntervalW-1:0] rd_data_q;
  logic [mwrm_pkg::IntervalW-1:0] elapsed_q;
  logic [mwrm_pkg::PosW-1:0]      pos_q;
  logic                           is_new_q;
  logic [mwrm_pkg::IntervalW-1:0] avg_q;
  logic [mwrm_pkg::RateQ8W-1:0]   rate_q8_q;
  logic [mwrm_pkg::RateIntW-1:0]  rate_rnd_q;
  logic                           zero_q;

  logic [mwrm_pkg::WinW-1:0]      win_clamped;
  logic [mwrm_pkg::PosW-1:0]      pos;
  logic [mwrm_pkg::CountW-1:0]    pos_next;
  logic [mwrm_pkg::IntervalW-1:0] old;
  logic [mwrm_pkg::SumW-1:0]      sum_d;
  logic                           div_busy;
  logic [mwrm_pkg::SumW-1:0]      div_quo;
  logic [mwrm_pkg::SumW-1:0]      div_dividend;
  logic [mwrm_pkg::IntervalW-1:0] div_divisor;
  logic [mwrm_pkg::StepW-1:0]     div_steps;
  logic [mwrm_pkg::RateQ8W-1:0]   q8_sel;
  logic [mwrm_pkg::RateQ8W:0]     q8_round;

  // Window size written by configuration is clamped to 1..MaxWindow.
  always_comb begin
    win_clamped = cfg_data_i;
    if (cfg_data_i == '0) begin
      win_clamped = mwrm_pkg::WinW'(1);
    end else if (cfg_data_i > mwrm_pkg::WIN_MAX) begin
      win_clamped = mwrm_pkg::WIN_MAX;
    end
  end

  // Slot taken by the incoming interval, and the slot after it.
  always_comb begin
    pos      = ({1'b0, wpos_q} >= win_q) ? '0 : wpos_q;
    pos_next = {1'b0, pos_q} + 1'b1;
    if (pos_next >= win_q) begin
      pos_next = '0;
    end
  end

  // A slot written for the first time since the last clear holds no old value.
  assign old   = is_new_q ? '0 : rd_data_q;
  assign sum_d = sum_q + mwrm_pkg::SumW'(elapsed_q) - mwrm_pkg::SumW'(old);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= mwrm_pkg::WIN_RESET;
      wpos_q   <= '0;
      filled_q <= '0;
      sum_q    <= '0;
    end else if (cmd_i.cfg_write) begin
      win_q    <= win_clamped;
      wpos_q   <= '0;
      filled_q <= '0;
      sum_q    <= '0;
    end else if (cmd_i.update) begin
      sum_q  <= sum_d;
      wpos_q <= pos_next[mwrm_pkg::PosW-1:0];
      if (is_new_q) begin
        filled_q <= {1'b0, pos_q} + 1'b1;
      end
    end
  end

  // Interval ring: read when a transaction is accepted, written on update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_data_q <= ring_q[pos];
    end
    if (cmd_i.update) begin
      ring_q[pos_q] <= elapsed_q;
    end
  end

  // Input capture and average capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elapsed_q <= elapsed_us_i;
      pos_q     <= pos;
      is_new_q  <= filled_q <= {1'b0, pos};
    end
    if (cmd_i.avg_capture) begin
      avg_q <= div_quo[mwrm_pkg::IntervalW-1:0];
    end
  end

  // The divider first forms sum / filled, then 256000000 / average.
  always_comb begin
    if (cmd_i.rate_start) begin
      div_dividend = {mwrm_pkg::RATE_Q8_MAX, {(mwrm_pkg::SumW-mwrm_pkg::RateQ8W){1'b0}}};
      div_divisor  = avg_q;
      div_steps    = mwrm_pkg::STEPS_RATE;
    end else begin
      div_dividend = sum_q;
      div_divisor  = mwrm_pkg::IntervalW'(filled_q);
      div_steps    = mwrm_pkg::STEPS_AVG;
    end
  end

  mwrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.avg_start | cmd_i.rate_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Rounded rate is the Q20.8 rate plus one half, truncated to an integer.
  always_comb begin
    q8_sel   = (avg_q == '0) ? mwrm_pkg::RATE_Q8_MAX : div_quo[mwrm_pkg::RateQ8W-1:0];
    q8_round = {1'b0, q8_sel} + mwrm_pkg::ROUND_HALF;
  end

  // Output register holds the result until the transaction completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rate_q8_q  <= q8_sel;
      rate_rnd_q <= q8_round[mwrm_pkg::RateQ8W-1:8];
      zero_q     <= avg_q == '0;
    end
  end

  assign status_o.div_busy = div_busy;
  assign status_o.avg_zero = avg_q == '0;
  assign rate_q8_o         = rate_q8_q;
  assign rate_rounded_o    = rate_rnd_q;
  assign zero_average_o    = zero_q;

endmodule

/* hdl/mwrm_ctrl.sv */
// Rate meter controller: sequences one tick through update and one or two divisions.
// Depends on mwrm_pkg.
module mwrm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  mwrm_pkg::mwrm_status_t   status_i,
  output mwrm_pkg::mwrm_cmd_t      cmd_o
);

  mwrm_pkg::mwrm_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  // The output register can be loaded when empty or when its transaction completes.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      mwrm_pkg::ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_stall_o  = cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = mwrm_pkg::ST_UPDATE;
        end
      end
      mwrm_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = mwrm_pkg::ST_AVG_START;
      end
      mwrm_pkg::ST_AVG_START: begin
        cmd_o.avg_start = 1'b1;
        state_d         = mwrm_pkg::ST_AVG_RUN;
      end
      mwrm_pkg::ST_AVG_RUN: begin
        if (!status_i.div_busy) begin
          cmd_o.avg_capture = 1'b1;
          state_d           = mwrm_pkg::ST_CHECK;
        end
      end
      mwrm_pkg::ST_CHECK: begin
        if (status_i.avg_zero) begin
          state_d = mwrm_pkg::ST_DONE;
        end else begin
          cmd_o.rate_start = 1'b1;
          state_d          = mwrm_pkg::ST_RATE_RUN;
        end
      end
      mwrm_pkg::ST_RATE_RUN: begin
        if (!status_i.div_busy) begin
          state_d = mwrm_pkg::ST_DONE;
        end
      end
      mwrm_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mwrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mwrm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid is set on load and cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwrm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/moving_window_rate_meter.sv */
// Top level of the moving window rate meter: controller plus datapath.
// Depends on mwrm_pkg, mwrm_ctrl, mwrm_datapath and assert_macros.svh.
//
//   Channel  Direction  Handshake                   Payload
//   in       input      in_valid_i / in_stall_o     elapsed_us_i
//   out      output     out_valid_o / out_stall_i   rate_q8_o, rate_rounded_o, zero_average_o
//   cfg      input      cfg_valid_i / cfg_ready_o   cfg_data_i (window size)
//
// A tick runs from acceptance to a loaded result through update, divider start,
// 31 average steps, capture, rate start, 28 rate steps, finish and load. With a zero
// average the rate division is skipped. The next tick is taken in the cycle after the
// load at the earliest. Reset is asynchronous and needs no clearing pass. A stalled
// output holds its result while the next tick is worked on; that result then waits
// and the input stalls.
`include "assert_macros.svh"

module moving_window_rate_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mwrm_pkg::IntervalW-1:0]    elapsed_us_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mwrm_pkg::RateQ8W-1:0]      rate_q8_o,
  output logic [mwrm_pkg::RateIntW-1:0]     rate_rounded_o,
  output logic                              zero_average_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mwrm_pkg::WinW-1:0]         cfg_data_i
);

  mwrm_pkg::mwrm_cmd_t    cmd;
  mwrm_pkg::mwrm_status_t status;

  mwrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mwrm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_data_i     (cfg_data_i),
    .elapsed_us_i   (elapsed_us_i),
    .rate_q8_o      (rate_q8_o),
    .rate_rounded_o (rate_rounded_o),
    .zero_average_o (zero_average_o)
  );

  // A tick in flight blocks both further ticks and configuration.
  `MWRM_ASSERT(a_busy_after_accept,
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o,
    "input not blocked after accept")

  // A zero average always comes with saturated rates.
  `MWRM_ASSERT(a_zero_saturates,
    out_valid_o && zero_average_o |-> rate_q8_o == mwrm_pkg::RATE_Q8_MAX
      && rate_rounded_o == mwrm_pkg::RATE_INT_MAX,
    "zero average without saturation")

  // A nonzero average fits in 24 bits, so the rate can never be zero.
  `MWRM_NEVER(a_rate_nonzero,
    out_valid_o && !zero_average_o && rate_q8_o == '0,
    "zero rate with nonzero average")

endmodule
